// ===== rtl/core/sha256sh_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by the controller, the datapath and the top level; no dependencies.
package sha256sh_pkg;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned WORD_BITS   = 32;

	typedef enum logic [1:0] {
		OP_ABSORB  = 2'd0,
		OP_DIGEST  = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_MSG  = 2'd0,
		KIND_PAD1 = 2'd1,
		KIND_PAD2 = 2'd2
	} blk_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic      absorb;
		logic      restart;
		logic      prep;
		logic      round;
		logic      fold;
		logic      emit_next;
		blk_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic fill_full;
		logic fill_hi;
		logic last_round;
		logic last_emit;
	} stat_t;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ===== rtl/core/sha256sh_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sha256sh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/sha256sh_ctrl.sv =====
// Controller state machine of the SHA-256 stream hasher.
// Depends on sha256sh_pkg; drives the datapath through cmd_t, reads stat_t.
module sha256sh_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             operation,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  sha256sh_pkg::stat_t    stat,
	output sha256sh_pkg::cmd_t     cmd
);

	sha256sh_pkg::state_t    state_q, state_d;
	sha256sh_pkg::blk_kind_t kind_q, kind_d;
	sha256sh_pkg::op_t       op;

	assign op = sha256sh_pkg::op_t'(operation);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256sh_pkg::ST_IDLE;
			kind_q  <= sha256sh_pkg::KIND_MSG;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			sha256sh_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (op)
						sha256sh_pkg::OP_ABSORB: begin
							if (stat.fill_full) begin
								state_d = sha256sh_pkg::ST_PREP;
								kind_d  = sha256sh_pkg::KIND_MSG;
							end
						end
						sha256sh_pkg::OP_DIGEST: begin
							state_d = sha256sh_pkg::ST_PREP;
							kind_d  = sha256sh_pkg::KIND_PAD1;
						end
						default: begin
							state_d = sha256sh_pkg::ST_IDLE;
						end
					endcase
				end
			end
			sha256sh_pkg::ST_PREP: begin
				state_d = sha256sh_pkg::ST_ROUND;
			end
			sha256sh_pkg::ST_ROUND: begin
				if (stat.last_round) begin
					state_d = sha256sh_pkg::ST_FOLD;
				end
			end
			sha256sh_pkg::ST_FOLD: begin
				unique case (kind_q)
					sha256sh_pkg::KIND_PAD1: begin
						if (stat.fill_hi) begin
							state_d = sha256sh_pkg::ST_PREP;
							kind_d  = sha256sh_pkg::KIND_PAD2;
						end else begin
							state_d = sha256sh_pkg::ST_EMIT;
						end
					end
					sha256sh_pkg::KIND_PAD2: begin
						state_d = sha256sh_pkg::ST_EMIT;
					end
					default: begin
						state_d = sha256sh_pkg::ST_IDLE;
					end
				endcase
			end
			sha256sh_pkg::ST_EMIT: begin
				if (out_ready && stat.last_emit) begin
					state_d = sha256sh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha256sh_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = (state_q == sha256sh_pkg::ST_IDLE);
		out_valid     = (state_q == sha256sh_pkg::ST_EMIT);
		cmd.absorb    = in_ready && in_valid && (op == sha256sh_pkg::OP_ABSORB);
		cmd.restart   = in_ready && in_valid && (op == sha256sh_pkg::OP_RESTART);
		cmd.prep      = (state_q == sha256sh_pkg::ST_PREP);
		cmd.round     = (state_q == sha256sh_pkg::ST_ROUND);
		cmd.fold      = (state_q == sha256sh_pkg::ST_FOLD);
		cmd.emit_next = out_valid && out_ready;
		cmd.kind      = kind_q;
	end

endmodule

// ===== rtl/core/sha256sh_dp.sv =====
// Datapath of the SHA-256 stream hasher: byte packing, block RAM, message
// schedule, round logic, chaining value and digest words. Depends on
// sha256sh_pkg and sha256sh_ram.
module sha256sh_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            data_byte,
	input  sha256sh_pkg::cmd_t    cmd,
	output sha256sh_pkg::stat_t   stat,
	output logic [31:0]           digest_word,
	output logic [2:0]            word_index,
	output logic                  last_word
);

	localparam int unsigned AW = $clog2(sha256sh_pkg::BLOCK_WORDS);

	logic [31:0] chain_q [8];
	logic [31:0] hv_q [8];
	logic [31:0] v_q [8];
	logic [31:0] win_q [16];
	logic [31:0] base [8];
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	logic [23:0] pack_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic [63:0]   bit_len;
	logic [3:0]    t_lo;
	logic [31:0]   partial, pad_word, blk_word, sched, wt;
	logic [31:0]   t1, t2;

	assign ram_we    = cmd.absorb && (fill_q[1:0] == 2'b11);
	assign ram_raddr = cmd.prep ? '0 : rnd_q[AW-1:0] + AW'(1);

	sha256sh_ram #(
		.WIDTH(sha256sh_pkg::WORD_BITS),
		.DEPTH(sha256sh_pkg::BLOCK_WORDS)
	) u_blk_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[5:2]),
		.wdata({pack_q, data_byte}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign bit_len = {total_q, 3'b000};
	assign t_lo    = rnd_q[3:0];

	always_comb begin
		unique case (fill_q[1:0])
			2'd0:    partial = {8'h80, 24'h000000};
			2'd1:    partial = {pack_q[7:0], 8'h80, 16'h0000};
			2'd2:    partial = {pack_q[15:0], 8'h80, 8'h00};
			default: partial = {pack_q[23:0], 8'h80};
		endcase

		if (t_lo < fill_q[5:2]) begin
			pad_word = ram_rdata;
		end else if (t_lo == fill_q[5:2]) begin
			pad_word = partial;
		end else if (!stat.fill_hi && t_lo == 4'd14) begin
			pad_word = bit_len[63:32];
		end else if (!stat.fill_hi && t_lo == 4'd15) begin
			pad_word = bit_len[31:0];
		end else begin
			pad_word = '0;
		end

		unique case (cmd.kind)
			sha256sh_pkg::KIND_MSG:  blk_word = ram_rdata;
			sha256sh_pkg::KIND_PAD1: blk_word = pad_word;
			sha256sh_pkg::KIND_PAD2: begin
				if (t_lo == 4'd14) begin
					blk_word = bit_len[63:32];
				end else if (t_lo == 4'd15) begin
					blk_word = bit_len[31:0];
				end else begin
					blk_word = '0;
				end
			end
			default: blk_word = '0;
		endcase

		sched = sha256sh_pkg::small_s1(win_q[14]) + win_q[9]
			+ sha256sh_pkg::small_s0(win_q[1]) + win_q[0];
		wt = (rnd_q[5:4] == 2'b00) ? blk_word : sched;

		t1 = v_q[7] + sha256sh_pkg::big_s1(v_q[4])
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256sh_pkg::ROUND_K[rnd_q] + wt;
		t2 = sha256sh_pkg::big_s0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

		for (int i = 0; i < 8; i++) begin
			base[i] = (cmd.kind == sha256sh_pkg::KIND_PAD2) ? hv_q[i] : chain_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256sh_pkg::INIT_HASH[i];
			end
			fill_q  <= '0;
			total_q <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= sha256sh_pkg::INIT_HASH[i];
				end
				fill_q  <= '0;
				total_q <= '0;
			end else if (cmd.absorb) begin
				fill_q  <= fill_q + 6'd1;
				total_q <= total_q + 61'd1;
			end
			if (cmd.fold && cmd.kind == sha256sh_pkg::KIND_MSG) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= base[i] + v_q[i];
				end
			end
			if (cmd.prep) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.fold) begin
				idx_q <= '0;
			end else if (cmd.emit_next) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			pack_q <= {pack_q[15:0], data_byte};
		end
		if (cmd.prep) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= base[i];
			end
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= wt;
		end
		if (cmd.fold && cmd.kind != sha256sh_pkg::KIND_MSG) begin
			for (int i = 0; i < 8; i++) begin
				hv_q[i] <= base[i] + v_q[i];
			end
		end
	end

	assign stat.fill_full  = (fill_q == 6'd63);
	assign stat.fill_hi    = (fill_q >= 6'd56);
	assign stat.last_round = (rnd_q == 6'd63);
	assign stat.last_emit  = (idx_q == 3'd7);

	assign digest_word = hv_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

endmodule

// ===== rtl/core/sha256_stream_hasher_core.sv =====
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Depends on sha256sh_pkg, sha256sh_ctrl and sha256sh_dp.
//
// Channel   Handshake              Payload
// input     in_valid / in_ready    operation[1:0], data_byte[7:0]
// output    out_valid / out_ready  digest_word[31:0], word_index[2:0], last_word
//
// Absorb and restart items are taken while idle; an absorb that completes a block
// stalls the input through the prep, round and fold states while the single round
// unit runs 64 rounds. A digest item stalls the input likewise, twice when the padding
// spills into a second block, then offers eight words, one per cycle that out_ready allows.
// Reset loads the initial hash values and clears the byte count; no sweep.
module sha256_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha256sh_pkg::cmd_t  cmd;
	sha256sh_pkg::stat_t stat;

	sha256sh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sha256sh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.cmd        (cmd),
		.stat       (stat),
		.digest_word(digest_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a digest is being delivered");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid && in_ready)
		else $error("digest delivery did not end after the last word");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
		out_valid && (word_index == $past(word_index) + 3'd1))
		else $error("digest word index did not advance by one");

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> word_index == 3'd0)
		else $error("digest delivery did not start at word zero");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the SHA-256 stream hasher: random byte streams with digests, restarts
// and ignored codes. A scoreboard class predicts every digest word. Needs sha256sh_pkg and
// sha256_stream_hasher_core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_IGNORED = 2'd3;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		logic [31:0] value;
		logic [2:0]  pos;
		logic        is_last;
	} due_word_t;

	class sha256_tracker;
		logic [255:0] chain;
		logic [511:0] msg_bits;
		logic [5:0]   fill;
		logic [60:0]  total;
		due_word_t    words_due [$];
		int unsigned  mismatches;

		function new();
			restart();
			msg_bits = '0;
			mismatches = 0;
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) begin
				chain[255 - 32 * i -: 32] = SHA_IV[i];
			end
			fill = '0;
			total = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function logic [255:0] compress_block(logic [255:0] hv, logic [511:0] blk);
			logic [31:0]  w [64];
			logic [31:0]  a, b, c, d, e, f, g, h, t1, t2;
			logic [255:0] mixed;
			logic [255:0] sum;
			for (int i = 0; i < 16; i++) begin
				w[i] = blk[511 - 32 * i -: 32];
			end
			for (int i = 16; i < 64; i++) begin
				w[i] = w[i - 16] + w[i - 7]
					+ (rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3))
					+ (rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10));
			end
			{a, b, c, d, e, f, g, h} = hv;
			for (int i = 0; i < 64; i++) begin
				t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
					+ SHA_K[i] + w[i];
				t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				h = g;
				g = f;
				f = e;
				e = d + t1;
				d = c;
				c = b;
				b = a;
				a = t1 + t2;
			end
			mixed = {a, b, c, d, e, f, g, h};
			for (int i = 0; i < 8; i++) begin
				sum[255 - 32 * i -: 32] = hv[255 - 32 * i -: 32] + mixed[255 - 32 * i -: 32];
			end
			return sum;
		endfunction

		function void queue_digest();
			logic [511:0] blk;
			logic [255:0] hv;
			due_word_t    due;
			blk = msg_bits;
			for (int i = 0; i < 64; i++) begin
				if (i >= int'(fill)) begin
					blk[511 - 8 * i -: 8] = 8'h00;
				end
			end
			blk[511 - 8 * int'(fill) -: 8] = 8'h80;
			hv = chain;
			if (fill >= 6'd56) begin
				hv = compress_block(hv, blk);
				blk = '0;
			end
			blk[63:0] = {total, 3'b000};
			hv = compress_block(hv, blk);
			for (int i = 0; i < 8; i++) begin
				due.value = hv[255 - 32 * i -: 32];
				due.pos = 3'(i);
				due.is_last = (i == 7);
				words_due.push_back(due);
			end
		endfunction

		function void take_item(logic [1:0] op, logic [7:0] value);
			case (op)
				sha256sh_pkg::OP_ABSORB: begin
					msg_bits[511 - 8 * int'(fill) -: 8] = value;
					fill = fill + 6'd1;
					total = total + 61'd1;
					if (fill == 6'd0) begin
						chain = compress_block(chain, msg_bits);
					end
				end
				sha256sh_pkg::OP_DIGEST: queue_digest();
				sha256sh_pkg::OP_RESTART: restart();
				default: ;
			endcase
		endfunction

		function void check_word(logic [31:0] value, logic [2:0] pos, logic is_last);
			due_word_t due;
			if (words_due.size() == 0) begin
				$display("%0t: digest word %h arrived with no digest pending", $time, value);
				mismatches++;
				return;
			end
			due = words_due.pop_front();
			if (value !== due.value) begin
				$display("%0t: digest_word expected %h, got %h", $time, due.value, value);
				mismatches++;
			end
			if (pos !== due.pos) begin
				$display("%0t: word_index expected %0d, got %0d", $time, due.pos, pos);
				mismatches++;
			end
			if (is_last !== due.is_last) begin
				$display("%0t: last_word expected %b, got %b", $time, due.is_last, is_last);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = sha256sh_pkg::OP_ABSORB;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_tracker tracker;
	int          burst_left = 0;
	int          items_sent = 0;
	int          stall_span = 0;
	logic [15:0] stall_pat = 16'hffff;

	sha256_stream_hasher_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_span = 64;
			stall_pat = ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
		end
		stall_span--;
		stall_pat = {stall_pat[14:0], stall_pat[15]};
		out_ready <= stall_pat[0];
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.check_word(digest_word, word_index, last_word);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] value);
		int idle;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			idle = $urandom_range(0, 7);
			if (idle != 0) begin
				in_valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= value;
		do @(posedge clk); while (!in_ready);
		tracker.take_item(op, value);
		items_sent++;
	endtask

	task automatic run_message();
		int  len;
		logic at_edge;
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 40);
		if ($urandom_range(0, 4) != 0) begin
			send_item(sha256sh_pkg::OP_RESTART, 8'($urandom));
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 29) == 0) begin
				send_item(OP_IGNORED, 8'($urandom));
			end
			at_edge = (tracker.fill == 6'd0) || (tracker.fill == 6'd55)
				|| (tracker.fill == 6'd56) || (tracker.fill == 6'd63);
			if ((at_edge && $urandom_range(0, 1) == 0) || $urandom_range(0, 15) == 0) begin
				send_item(sha256sh_pkg::OP_DIGEST, 8'($urandom));
			end
			send_item(sha256sh_pkg::OP_ABSORB, 8'($urandom));
		end
		send_item(sha256sh_pkg::OP_DIGEST, 8'($urandom));
	endtask

	initial begin
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, ignored code, the three-byte vector and a repeated digest.
		send_item(sha256sh_pkg::OP_DIGEST, 8'hff);
		send_item(OP_IGNORED, 8'hff);
		send_item(sha256sh_pkg::OP_ABSORB, 8'h61);
		send_item(sha256sh_pkg::OP_ABSORB, 8'h62);
		send_item(sha256sh_pkg::OP_ABSORB, 8'h63);
		send_item(sha256sh_pkg::OP_DIGEST, 8'h00);
		send_item(sha256sh_pkg::OP_DIGEST, 8'h55);
		send_item(sha256sh_pkg::OP_ABSORB, 8'h00);
		send_item(sha256sh_pkg::OP_ABSORB, 8'hff);
		send_item(OP_IGNORED, 8'h00);
		send_item(sha256sh_pkg::OP_DIGEST, 8'haa);
		send_item(sha256sh_pkg::OP_RESTART, 8'hff);
		send_item(sha256sh_pkg::OP_DIGEST, 8'h00);
		send_item(sha256sh_pkg::OP_RESTART, 8'h00);
		send_item(sha256sh_pkg::OP_ABSORB, 8'hff);
		send_item(sha256sh_pkg::OP_ABSORB, 8'h80);
		send_item(sha256sh_pkg::OP_ABSORB, 8'h7f);
		send_item(sha256sh_pkg::OP_ABSORB, 8'h01);
		send_item(sha256sh_pkg::OP_DIGEST, 8'h00);

		while (items_sent < 300) begin
			run_message();
		end

		in_valid <= 1'b0;
		while (tracker.words_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.words_due.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("testbench: done, errors");
		$finish;
	end
endmodule

// ===== sha256_stream_hasher_core.f =====
rtl/core/sha256sh_pkg.sv
rtl/core/sha256sh_ram.sv
rtl/core/sha256sh_ctrl.sv
rtl/core/sha256sh_dp.sv
rtl/core/sha256_stream_hasher_core.sv
bench/testbench.sv
